>>> design/signed_int_to_radix_digits_top_assert.svh
// Assertion macros for the signed integer to radix digits block.
// Included by the top level; no other dependencies.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_TOP_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_TOP_ASSERT_SVH

// same-cycle implication
`define SIRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sird: same-cycle check failed");

// next-cycle implication
`define SIRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sird: next-cycle check failed");

`endif

>>> design/sird_pkg.sv
// Shared types, constants and helper functions for the radix digit block.
// No dependencies.
package sird_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int VAL_W           = 32;
    localparam int SYM_W           = 8;
    localparam int DIG_W           = 4;
    localparam int RLEN_W          = 5;
    localparam int CFG_W           = 64;
    localparam int ADDR_W          = 5;
    localparam int MAX_DIG         = 32;
    localparam int ND_W            = 6;
    localparam int STK_W           = MAX_DIG * DIG_W;
    localparam int REM_W           = 6;
    localparam int MIN_RADIX       = 2;
    localparam int Q_DEPTH         = 2;
    localparam int PTR_W           = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W           = $clog2(Q_DEPTH + 1);

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

    // register indexes (paddr[4:3])
    localparam logic [1:0] REG_RADIX_LEN = 2'd0;
    localparam logic [1:0] REG_SYMS_LO   = 2'd1;
    localparam logic [1:0] REG_SYMS_HI   = 2'd2;

    typedef struct packed {
        logic [RLEN_W-1:0] radix_len;
        logic [CFG_W-1:0]  syms_hi;
        logic [CFG_W-1:0]  syms_lo;
    } t_cfg;

    typedef struct packed {
        logic             neg;
        logic [VAL_W-1:0] mag;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [SYM_W-1:0] sym_at(t_cfg c, logic [DIG_W-1:0] k);
        logic [2*CFG_W-1:0] all;
        all = {c.syms_hi, c.syms_lo};
        return all[{k, 3'b000} +: SYM_W];
    endfunction

    // floor(2^32 / r); quotient estimate from it is low by at most one
    function automatic logic [VAL_W-1:0] recip(logic [RLEN_W-1:0] r);
        logic [VAL_W-1:0] m;
        unique case (r)
            5'd2:    m = 32'h8000_0000;
            5'd3:    m = 32'h5555_5555;
            5'd4:    m = 32'h4000_0000;
            5'd5:    m = 32'h3333_3333;
            5'd6:    m = 32'h2AAA_AAAA;
            5'd7:    m = 32'h2492_4924;
            5'd8:    m = 32'h2000_0000;
            5'd9:    m = 32'h1C71_C71C;
            5'd10:   m = 32'h1999_9999;
            5'd11:   m = 32'h1745_D174;
            5'd12:   m = 32'h1555_5555;
            5'd13:   m = 32'h13B1_3B13;
            5'd14:   m = 32'h1249_2492;
            5'd15:   m = 32'h1111_1111;
            5'd16:   m = 32'h1000_0000;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> design/sird_in_if.sv
// Input channel: one signed value per word.
// Depends on sird_pkg.
interface sird_in_if;
    import sird_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

>>> design/sird_out_if.sv
// Output channel: one symbol byte per word, with end-of-value flag.
// Depends on sird_pkg.
interface sird_out_if;
    import sird_pkg::*;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

>>> design/sird_front.sv
// Front stage: takes input words, checks the alphabet, forms sign and magnitude.
// Depends on sird_pkg and sird_in_if.
module sird_front #(
    parameter int MAX_SYMBOLS = sird_pkg::MAX_SYMBOLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sird_in_if.sink       i_in,
    input  sird_pkg::t_cfg i_cfg,
    output logic          o_push_vld,
    output sird_pkg::t_job o_push_job,
    input  logic          i_push_rdy,
    output logic          o_cfg_ok
);
    import sird_pkg::*;

    logic             r_vld;
    t_job             r_job;
    logic             w_bad;
    logic             w_accept;
    logic             w_neg;
    logic [VAL_W-1:0] w_raw;
    logic [VAL_W-1:0] w_mag;

    // all active symbols compared pairwise in parallel; NUL, '+', '-' rejected too
    always_comb begin
        w_bad = 1'b0;
        for (int a = 0; a < MAX_SYMBOLS; a++) begin
            if (RLEN_W'(a) < i_cfg.radix_len) begin
                if (sym_at(i_cfg, DIG_W'(a)) == '0 || sym_at(i_cfg, DIG_W'(a)) == CH_PLUS ||
                    sym_at(i_cfg, DIG_W'(a)) == CH_MINUS) begin
                    w_bad = 1'b1;
                end
                for (int b = a + 1; b < MAX_SYMBOLS; b++) begin
                    if (RLEN_W'(b) < i_cfg.radix_len &&
                        sym_at(i_cfg, DIG_W'(b)) == sym_at(i_cfg, DIG_W'(a))) begin
                        w_bad = 1'b1;
                    end
                end
            end
        end
    end

    assign o_cfg_ok = (i_cfg.radix_len >= RLEN_W'(MIN_RADIX)) &&
                      (i_cfg.radix_len <= RLEN_W'(MAX_SYMBOLS)) && !w_bad;

    assign i_in.ready = !r_vld || i_push_rdy;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_raw      = i_in.value;
    assign w_neg      = w_raw[VAL_W-1];
    assign w_mag      = w_neg ? (~w_raw + VAL_W'(1)) : w_raw;

    // words seen with a bad alphabet are dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= o_cfg_ok;
        end else if (i_push_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job.neg <= w_neg;
            r_job.mag <= w_mag;
        end
    end

    assign o_push_vld = r_vld;
    assign o_push_job = r_job;

endmodule

>>> design/sird_queue.sv
// Short job queue between front and back stages.
// Depends on sird_pkg.
module sird_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_vld,
    input  sird_pkg::t_job  i_push_job,
    output logic            o_push_rdy,
    output logic            o_pop_vld,
    output sird_pkg::t_job  o_pop_job,
    input  logic            i_pop,
    output sird_pkg::t_qstat o_stat
);
    import sird_pkg::*;

    t_job             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_stat.full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_push_rdy   = !o_stat.full;
    assign o_pop_vld    = !o_stat.empty;
    assign o_pop_job    = r_mem[r_rptr];
    assign w_push       = i_push_vld && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (w_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

endmodule

>>> design/sird_back.sv
// Back stage: divides out digits by reciprocal multiply, then emits them MSB first.
// Depends on sird_pkg and sird_out_if.
module sird_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sird_pkg::t_cfg i_cfg,
    input  logic           i_job_vld,
    input  sird_pkg::t_job i_job,
    output logic           o_pop,
    sird_out_if.source     o_out
);
    import sird_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_FIX, S_SIGN, S_EMIT} t_state;

    t_state             r_state;
    logic               r_ovld;
    logic [SYM_W-1:0]   r_osym;
    logic               r_olast;
    logic               r_neg;
    logic [VAL_W-1:0]   r_mag;
    logic [VAL_W-1:0]   r_qest;
    logic [STK_W-1:0]   r_stk;
    logic [ND_W-1:0]    r_nd;

    logic [2*VAL_W-1:0]        w_prod;
    logic [REM_W+RLEN_W-1:0]   w_qr;
    logic [REM_W-1:0]          w_rem;
    logic [REM_W-1:0]          w_rem_fix;
    logic                      w_corr;
    logic [DIG_W-1:0]          w_digit;
    logic [VAL_W-1:0]          w_q;
    logic                      w_slot;
    logic                      w_emit;

    assign w_prod = (2*VAL_W)'(r_mag) * (2*VAL_W)'(recip(i_cfg.radix_len));

    // remainder is below twice the radix, so its low bits are enough
    assign w_qr      = (REM_W+RLEN_W)'(r_qest[REM_W-1:0]) * (REM_W+RLEN_W)'(i_cfg.radix_len);
    assign w_rem     = r_mag[REM_W-1:0] - w_qr[REM_W-1:0];
    assign w_corr    = (w_rem >= REM_W'(i_cfg.radix_len));
    assign w_rem_fix = w_corr ? (w_rem - REM_W'(i_cfg.radix_len)) : w_rem;
    assign w_digit   = w_rem_fix[DIG_W-1:0];
    assign w_q       = r_qest + VAL_W'(w_corr);

    assign w_slot = !r_ovld || o_out.ready;
    assign w_emit = w_slot && (r_state == S_SIGN || r_state == S_EMIT);
    assign o_pop  = (r_state == S_IDLE) && i_job_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            if (o_out.ready && !w_emit) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_vld) begin
                        r_mag   <= i_job.mag;
                        r_neg   <= i_job.neg;
                        r_nd    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_qest  <= w_prod[2*VAL_W-1:VAL_W];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    // digits pushed in at the low end, popped from there too
                    r_stk <= {r_stk[STK_W-DIG_W-1:0], w_digit};
                    r_nd  <= r_nd + ND_W'(1);
                    r_mag <= w_q;
                    if (w_q == '0) begin
                        r_state <= r_neg ? S_SIGN : S_EMIT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_SIGN: begin
                    if (w_slot) begin
                        r_ovld  <= 1'b1;
                        r_osym  <= CH_MINUS;
                        r_olast <= 1'b0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_ovld  <= 1'b1;
                        r_osym  <= sym_at(i_cfg, r_stk[DIG_W-1:0]);
                        r_olast <= (r_nd == ND_W'(1));
                        r_stk   <= r_stk >> DIG_W;
                        r_nd    <= r_nd - ND_W'(1);
                        if (r_nd == ND_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid  = r_ovld;
    assign o_out.symbol = r_osym;
    assign o_out.last   = r_olast;

endmodule

>>> design/signed_int_to_radix_digits_top.sv
// Top level of the signed integer to radix digits block: config registers,
// front stage, job queue and digit back stage. Depends on sird_pkg, the
// channel interfaces, sird_front, sird_queue, sird_back and the assert header.
//
// i_in takes one signed 32-bit value per word; o_out gives its text, one
// symbol byte per word, most significant digit first, a '-' word ahead of
// negative values, and last set on the final digit. Bad alphabets give none.
// The APB port holds radix_len at 0x00, symbols 0-7 at 0x08, 8-15 at 0x10;
// write it only while the block is idle.
// A value with n digits runs the divide loop once per digit, each pass one
// 32x32 reciprocal multiply and one correction; then its words go out in
// order. The back stage takes a new value only once it has offered the
// last word of the one before.
// The front stage and a two-deep queue let input words be taken while the
// back stage works or while o_out is stalled; a stalled o_out holds its word.
// Reset empties the pipeline and clears the config registers to zero (no radix).
`include "signed_int_to_radix_digits_top_assert.svh"

module signed_int_to_radix_digits_top #(
    parameter int MAX_SYMBOLS = sird_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sird_in_if.sink                       i_in,
    sird_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sird_pkg::ADDR_W-1:0]   paddr,
    input  logic [sird_pkg::CFG_W-1:0]    pwdata,
    output logic [sird_pkg::CFG_W-1:0]    prdata,
    output logic                          pready
);
    import sird_pkg::*;

    logic [RLEN_W-1:0] r_radix_len;
    logic [CFG_W-1:0]  r_syms_lo;
    logic [CFG_W-1:0]  r_syms_hi;
    logic [1:0]        w_idx;
    logic              w_wr;
    t_cfg              w_cfg;
    logic              w_cfg_ok;
    logic              w_push_vld;
    t_job              w_push_job;
    logic              w_push_rdy;
    logic              w_pop_vld;
    t_job              w_pop_job;
    logic              w_pop;
    t_qstat            w_qstat;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_len <= '0;
            r_syms_lo   <= '0;
            r_syms_hi   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_RADIX_LEN: r_radix_len <= pwdata[RLEN_W-1:0];
                REG_SYMS_LO:   r_syms_lo   <= pwdata;
                REG_SYMS_HI:   r_syms_hi   <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_RADIX_LEN: prdata = CFG_W'(r_radix_len);
            REG_SYMS_LO:   prdata = r_syms_lo;
            REG_SYMS_HI:   prdata = r_syms_hi;
            default:       prdata = '0;
        endcase
    end

    assign w_cfg.radix_len = r_radix_len;
    assign w_cfg.syms_lo   = r_syms_lo;
    assign w_cfg.syms_hi   = r_syms_hi;

    sird_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg      (w_cfg),
        .o_push_vld (w_push_vld),
        .o_push_job (w_push_job),
        .i_push_rdy (w_push_rdy),
        .o_cfg_ok   (w_cfg_ok)
    );

    sird_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (w_push_vld),
        .i_push_job (w_push_job),
        .o_push_rdy (w_push_rdy),
        .o_pop_vld  (w_pop_vld),
        .o_pop_job  (w_pop_job),
        .i_pop      (w_pop),
        .o_stat     (w_qstat)
    );

    sird_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_job_vld (w_pop_vld),
        .i_job     (w_pop_job),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

    // a word taken with a bad alphabet must not reach the queue
    `SIRD_ASSERT_NXT(a_drop_bad_alphabet, i_clk, i_rst_n, i_in.valid && i_in.ready && !w_cfg_ok, !w_push_vld)
    `SIRD_ASSERT_IMP(a_queue_flags, i_clk, i_rst_n, w_qstat.full, !w_qstat.empty)
    // a push always leaves something in the queue, whatever the back stage pops
    `SIRD_ASSERT_NXT(a_push_lands, i_clk, i_rst_n, w_push_vld && w_push_rdy, !w_qstat.empty)

endmodule
